[src/hidapdu_pkg.sv]
// shared types and constants for the hid apdu report deframer
`timescale 1ns / 1ps
`default_nettype none

package hidapdu_pkg;

	// expected channel after reset, apdu tag, status word for success
	localparam logic [15:0] CHANNEL_RESET = 16'h0101;
	localparam logic [7:0]  APDU_TAG      = 8'h05;
	localparam logic [15:0] STATUS_OK     = 16'h9000;

	// header counter positions
	localparam logic [2:0] HC_CHAN_LO  = 3'd1;
	localparam logic [2:0] HC_TAG      = 3'd2;
	localparam logic [2:0] HC_SEQ_LO   = 3'd4;
	localparam logic [2:0] HC_SEQ_DONE = 3'd5;
	localparam logic [2:0] HC_LEN_LO   = 3'd6;
	localparam logic [2:0] HC_PAYLOAD  = 3'd7;

	// result kinds
	localparam logic [2:0] KIND_NONE      = 3'd0;
	localparam logic [2:0] KIND_RESP_BYTE = 3'd1;
	localparam logic [2:0] KIND_DONE_OK   = 3'd2;
	localparam logic [2:0] KIND_STATUS_ERR = 3'd3;
	localparam logic [2:0] KIND_HEADER_ERR = 3'd4;
	localparam logic [2:0] KIND_UNEXP_START = 3'd5;
	localparam logic [2:0] KIND_SHORT_LEN = 3'd6;

	// one incoming report byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       report_end;
	} in_item_t;

	// one result
	typedef struct packed {
		logic [2:0]  out_kind;
		logic [7:0]  out_byte;
		logic [15:0] out_position;
		logic [15:0] status_word;
	} out_item_t;

endpackage

`default_nettype wire

[src/hidapdu_parser.sv]
// per-byte header, length and payload tracking for apdu reports
`timescale 1ns / 1ps
`default_nettype none

module hidapdu_parser (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step_en,
	input  wire hidapdu_pkg::in_item_t item,
	input  wire logic [15:0]           expected_chan,
	output hidapdu_pkg::out_item_t     result
);
	import hidapdu_pkg::*;

	logic [2:0]  header_count_q, header_count_d;
	logic [15:0] header_shift_q, header_shift_d;
	logic [15:0] remaining_q, remaining_d;
	logic [15:0] position_q, position_d;
	logic [15:0] status_shift_q, status_shift_d;
	logic        in_message_q, in_message_d;
	logic        skip_report_q, skip_report_d;

	logic [15:0] hs_shifted;
	logic [15:0] st_shifted;

	assign hs_shifted = {header_shift_q[7:0], item.data_byte};
	assign st_shifted = {status_shift_q[7:0], item.data_byte};

	// next state and result for one byte
	always_comb begin
		header_count_d = header_count_q;
		header_shift_d = header_shift_q;
		remaining_d    = remaining_q;
		position_d     = position_q;
		status_shift_d = status_shift_q;
		in_message_d   = in_message_q;
		skip_report_d  = skip_report_q;
		result         = '0;

		if (!skip_report_q) begin
			if (header_count_q != HC_PAYLOAD) begin
				header_shift_d = hs_shifted;
				case (header_count_q)
					HC_CHAN_LO: begin
						if (hs_shifted != expected_chan) begin
							result.out_kind = KIND_HEADER_ERR;
							skip_report_d   = 1'b1;
						end
						header_count_d = HC_TAG;
					end
					HC_TAG: begin
						if (item.data_byte != APDU_TAG) begin
							result.out_kind = KIND_HEADER_ERR;
							skip_report_d   = 1'b1;
						end
						header_count_d = header_count_q + 3'd1;
					end
					HC_SEQ_LO: begin
						if (hs_shifted == 16'd0) begin
							if (in_message_q) begin
								result.out_kind = KIND_UNEXP_START;
								skip_report_d   = 1'b1;
							end
							header_count_d = HC_SEQ_DONE;
						end else begin
							// continuation with no open message is ignored
							if (!in_message_q) begin
								skip_report_d = 1'b1;
							end
							header_count_d = HC_PAYLOAD;
						end
					end
					HC_LEN_LO: begin
						if (hs_shifted < 16'd2) begin
							result.out_kind = KIND_SHORT_LEN;
							skip_report_d   = 1'b1;
						end else begin
							remaining_d    = hs_shifted;
							position_d     = 16'd0;
							status_shift_d = 16'd0;
							in_message_d   = 1'b1;
						end
						header_count_d = HC_PAYLOAD;
					end
					default: begin
						header_count_d = header_count_q + 3'd1;
					end
				endcase
			end else if (in_message_q && (remaining_q != 16'd0)) begin
				// payload phase: data bytes, then the two status bytes
				if (remaining_q > 16'd2) begin
					result.out_kind     = KIND_RESP_BYTE;
					result.out_byte     = item.data_byte;
					result.out_position = position_q;
				end else begin
					status_shift_d = st_shifted;
					if (remaining_q == 16'd1) begin
						result.out_kind    = (st_shifted == STATUS_OK) ?
							KIND_DONE_OK : KIND_STATUS_ERR;
						result.status_word = st_shifted;
						in_message_d       = 1'b0;
					end
				end
				remaining_d = remaining_q - 16'd1;
				position_d  = position_q + 16'd1;
			end
		end

		// every report end restarts header parsing
		if (item.report_end) begin
			header_count_d = 3'd0;
			header_shift_d = 16'd0;
			skip_report_d  = 1'b0;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_count_q <= 3'd0;
			header_shift_q <= 16'd0;
			remaining_q    <= 16'd0;
			position_q     <= 16'd0;
			status_shift_q <= 16'd0;
			in_message_q   <= 1'b0;
			skip_report_q  <= 1'b0;
		end else if (step_en) begin
			header_count_q <= header_count_d;
			header_shift_q <= header_shift_d;
			remaining_q    <= remaining_d;
			position_q     <= position_d;
			status_shift_q <= status_shift_d;
			in_message_q   <= in_message_d;
			skip_report_q  <= skip_report_d;
		end
	end

endmodule

`default_nettype wire

[src/hid_apdu_report_deframer.sv]
// top level: input register, parser, result register and channel register
// an accepted byte passes the input register, parser and result register
// throughput: one byte per cycle unless result_stall holds the output, one
// result per byte, limited by the single parser state update per byte
// reset: asynchronous, clears all parser state and the valid flags of both
// pipeline registers, expected channel returns to 0x0101
`timescale 1ns / 1ps
`default_nettype none

module hid_apdu_report_deframer (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   byte_valid,
	output logic                        byte_stall,
	input  wire hidapdu_pkg::in_item_t  byte_data,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output hidapdu_pkg::out_item_t      result_data,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [15:0]            cfg_data
);
	import hidapdu_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	out_item_t result_s2;
	out_item_t step_result;
	logic      advance;
	logic      step_en;
	logic [15:0] channel_q;

	assign advance      = !result_valid || !result_stall;
	assign step_en      = valid_s1 && advance;
	assign byte_stall   = valid_s1 && !advance;
	assign cfg_ready    = 1'b1;
	assign result_data  = result_s2;

	// channel register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q <= CHANNEL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			channel_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			item_s1 <= byte_data;
		end
	end

	hidapdu_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (step_en),
		.item          (item_s1),
		.expected_chan (channel_q),
		.result        (step_result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			result_s2 <= step_result;
		end
	end

	// checks
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_stall |=> valid_s1)
		else $error("accepted byte did not reach the input register");

	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> result_valid)
		else $error("processed byte produced no result");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_data.out_kind <= KIND_SHORT_LEN)
		else $error("result kind out of range");

	a_byte_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.out_kind != KIND_RESP_BYTE
		|-> result_data.out_byte == 8'd0 && result_data.out_position == 16'd0)
		else $error("byte fields set on a non-byte result");

endmodule

`default_nettype wire
